// ===== sv/assert_macros.svh =====
// assertion helpers used by bmf_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BMF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bmf assertion failed");

// checked on every edge, reset included
`define BMF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bmf assertion failed");

`endif

// ===== sv/bmf_pkg.sv =====
`default_nettype none

package bmf_pkg;

    localparam int MAX_BAR_WIDTH = 64;

    localparam int PIX_BITS   = 8;
    localparam int BAR_W_BITS = 7;

    // longest delay needed is 2w+1, entry cell sits at delay-1
    localparam int LINE_LEN  = 2 * MAX_BAR_WIDTH + 1;
    localparam int DLY_BITS  = $clog2(LINE_LEN + 1);

    // window sums: center window of w pixels, surround span of 2w pixels
    localparam int P_BITS = $clog2(MAX_BAR_WIDTH * 255 + 1);
    localparam int T_BITS = $clog2(2 * MAX_BAR_WIDTH * 255 + 1);
    localparam int D_BITS = T_BITS + 1;

    localparam logic [PIX_BITS-1:0] PIX_MAX = '1;

    typedef enum logic [1:0] {
        GAIN_NONE = 2'd0,
        GAIN_ONE  = 2'd1,
        GAIN_TWO  = 2'd2
    } t_gain;

endpackage

`default_nettype wire

// ===== sv/bmf_cell.sv =====
`default_nettype none

module bmf_cell import bmf_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_shift,
    input  wire logic                i_load,
    input  wire logic                i_clear,
    input  wire logic [PIX_BITS-1:0] i_pixel,
    input  wire logic [PIX_BITS-1:0] i_next,
    output logic      [PIX_BITS-1:0] o_value
);

    logic [PIX_BITS-1:0] r_value;
    logic [PIX_BITS-1:0] n_value;

    // the entry cell takes the new pixel, a row start flushes the rest
    always_comb begin
        if (i_load) begin
            n_value = i_pixel;
        end else if (i_clear) begin
            n_value = '0;
        end else begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== sv/bmf_line.sv =====
`default_nettype none

// variable delay line: the pixel enters at cell delay-1 and walks down to cell 0
module bmf_line import bmf_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_shift,
    input  wire logic                i_clear,
    input  wire logic [DLY_BITS-1:0] i_delay,
    input  wire logic [PIX_BITS-1:0] i_pixel,
    output logic      [PIX_BITS-1:0] o_tap
);

    logic [PIX_BITS-1:0] cell_value [LINE_LEN];

    for (genvar i = 0; i < LINE_LEN; i++) begin : g_cell
        logic                load;
        logic [PIX_BITS-1:0] next;

        assign load = (i_delay == DLY_BITS'(i + 1));

        if (i == LINE_LEN - 1) begin : g_top
            assign next = '0;
        end else begin : g_mid
            assign next = cell_value[i+1];
        end

        bmf_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_load  (load),
            .i_clear (i_clear),
            .i_pixel (i_pixel),
            .i_next  (next),
            .o_value (cell_value[i])
        );
    end

    assign o_tap = cell_value[0];

endmodule

`default_nettype wire

// ===== sv/lane_marking_bar_filter.sv =====
// the window sums are registered on accept, then the clipped response in the output register
// throughput: one pixel per clock unless stalled, set by the per-pixel update of both window sums
// the delay lines are cell chains that load the pixel at the tap distance, so no tap search
// reset (i_rst_n low, synchronous) empties the pipeline and sets the row width to zero,
// so the output stays 0 until the first line start; a line start flushes the history
`default_nettype none

module lane_marking_bar_filter import bmf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIX_BITS-1:0]   i_pixel,
    input  wire logic                  i_line_start,
    input  wire logic [BAR_W_BITS-1:0] i_bar_width,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [PIX_BITS-1:0]   o_filtered
);

    // row state
    logic [BAR_W_BITS-1:0] r_row_width;
    logic [PIX_BITS-1:0]   r_prev_pix;
    logic [P_BITS-1:0]     r_p;
    logic [T_BITS-1:0]     r_t;

    // pipeline control
    logic                  r_a_valid;
    t_gain                 r_a_gain;
    logic                  r_out_valid;
    logic [PIX_BITS-1:0]   r_out_filtered;

    logic                  accept;
    logic                  advance;
    logic                  ls;
    logic [BAR_W_BITS-1:0] w_sat;
    logic [BAR_W_BITS-1:0] w_cur;
    logic [DLY_BITS-1:0]   dly_center;
    logic [DLY_BITS-1:0]   dly_center_end;
    logic [DLY_BITS-1:0]   dly_span_end;
    logic [PIX_BITS-1:0]   tap_center;
    logic [PIX_BITS-1:0]   tap_center_end;
    logic [PIX_BITS-1:0]   tap_span_end;
    logic [PIX_BITS-1:0]   x_in_center;
    logic [PIX_BITS-1:0]   x_out_center;
    logic [PIX_BITS-1:0]   x_in_span;
    logic [PIX_BITS-1:0]   x_out_span;
    logic [P_BITS-1:0]     p_base;
    logic [T_BITS-1:0]     t_base;
    logic [P_BITS-1:0]     n_p;
    logic [T_BITS-1:0]     n_t;
    t_gain                 n_gain;

    logic [T_BITS-1:0]        scaled;
    logic signed [D_BITS-1:0] diff;
    logic [PIX_BITS-1:0]      n_out_filtered;

    assign o_stall = r_a_valid & r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign advance = r_a_valid & (~r_out_valid | ~i_stall);

    assign ls    = i_line_start;
    assign w_sat = (i_bar_width > BAR_W_BITS'(MAX_BAR_WIDTH)) ?
                   BAR_W_BITS'(MAX_BAR_WIDTH) : i_bar_width;
    assign w_cur = ls ? w_sat : r_row_width;

    // center window covers distances w/2 .. w/2+w-1, surround span 1 .. 2w
    assign dly_center     = DLY_BITS'(w_cur >> 1);
    assign dly_center_end = DLY_BITS'(w_cur >> 1) + DLY_BITS'(w_cur);
    assign dly_span_end   = DLY_BITS'({w_cur, 1'b0}) + DLY_BITS'(1);

    bmf_line u_line_center (
        .i_clk   (i_clk),
        .i_shift (accept),
        .i_clear (ls),
        .i_delay (dly_center),
        .i_pixel (i_pixel),
        .o_tap   (tap_center)
    );

    bmf_line u_line_center_end (
        .i_clk   (i_clk),
        .i_shift (accept),
        .i_clear (ls),
        .i_delay (dly_center_end),
        .i_pixel (i_pixel),
        .o_tap   (tap_center_end)
    );

    bmf_line u_line_span_end (
        .i_clk   (i_clk),
        .i_shift (accept),
        .i_clear (ls),
        .i_delay (dly_span_end),
        .i_pixel (i_pixel),
        .o_tap   (tap_span_end)
    );

    // pixels from before the row start count as zero
    always_comb begin
        x_in_center  = (w_cur < BAR_W_BITS'(2)) ? i_pixel : (ls ? '0 : tap_center);
        x_out_center = ls ? '0 : tap_center_end;
        x_in_span    = ls ? '0 : r_prev_pix;
        x_out_span   = ls ? '0 : tap_span_end;
        p_base       = ls ? '0 : r_p;
        t_base       = ls ? '0 : r_t;
        n_p = p_base + P_BITS'(x_in_center) - P_BITS'(x_out_center);
        n_t = t_base + T_BITS'(x_in_span) - T_BITS'(x_out_span);
        if (w_cur == '0) begin
            n_gain = GAIN_NONE;
        end else if (w_cur == BAR_W_BITS'(1)) begin
            n_gain = GAIN_ONE;
        end else begin
            n_gain = GAIN_TWO;
        end
    end

    // center +1 net: twice center minus span from width 2, center minus span at width 1, else 0
    always_comb begin
        case (r_a_gain)
            GAIN_TWO: scaled = T_BITS'({r_p, 1'b0});
            GAIN_ONE: scaled = T_BITS'(r_p);
            default:  scaled = '0;
        endcase
        diff = $signed(D_BITS'(scaled)) - $signed(D_BITS'(r_t));
        if (r_a_gain == GAIN_NONE || diff[D_BITS-1]) begin
            n_out_filtered = '0;
        end else if (diff > $signed(D_BITS'(PIX_MAX))) begin
            n_out_filtered = PIX_MAX;
        end else begin
            n_out_filtered = PIX_BITS'(diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_a_gain    <= GAIN_NONE;
        end else begin
            if (accept) begin
                r_row_width <= w_cur;
                r_a_gain    <= n_gain;
            end
            r_a_valid   <= accept | (r_a_valid & ~advance);
            r_out_valid <= advance | (r_out_valid & i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_pix <= i_pixel;
            r_p        <= n_p;
            r_t        <= n_t;
        end
        if (advance) begin
            r_out_filtered <= n_out_filtered;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_filtered;

endmodule

`default_nettype wire

// ===== sv/bmf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module bmf_checker import bmf_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_stall,
    input wire logic [PIX_BITS-1:0]   i_pixel,
    input wire logic                  i_line_start,
    input wire logic [BAR_W_BITS-1:0] i_bar_width,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [PIX_BITS-1:0]   o_filtered
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] r_inflight;

    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = o_valid & ~i_stall;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_acc) - 3'(out_acc);
        end
    end

    `BMF_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid)
    `BMF_ASSERT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_filtered))
    `BMF_ASSERT(a_two_in_flight, i_clk, i_rst_n, r_inflight <= 3'd2)
    `BMF_ASSERT(a_no_invented, i_clk, i_rst_n, o_valid |-> r_inflight != 3'd0)
    `BMF_ASSERT(a_idle_takes, i_clk, i_rst_n, r_inflight == 3'd0 |-> !o_stall)

endmodule

bind lane_marking_bar_filter bmf_checker u_bmf_checker (.*);

`default_nettype wire

// ===== dv/lane_marking_bar_filter_tb.sv =====
module lane_marking_bar_filter_tb;
    import bmf_pkg::*;

    localparam int HIST_LEN = 2 * MAX_BAR_WIDTH;
    localparam int N_ITEMS  = 1300;
    localparam int N_CALM   = 150;

    typedef struct packed {
        logic [PIX_BITS-1:0]   pix;
        logic                  start;
        logic [BAR_W_BITS-1:0] bw;
        logic                  known;
        logic [PIX_BITS-1:0]   filt;
    } t_stim_row;

    localparam int N_DIRECTED = 25;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [PIX_BITS-1:0]   i_pixel;
    logic                  i_line_start;
    logic [BAR_W_BITS-1:0] i_bar_width;
    logic                  o_valid;
    logic                  i_stall;
    logic [PIX_BITS-1:0]   o_filtered;

    // predictor state
    logic [PIX_BITS-1:0] pix_hist [HIST_LEN];
    int                  line_pos;
    int                  row_w;

    logic [PIX_BITS-1:0] expected_filtered [$];

    int  n_errors;
    int  n_items;
    int  n_rows;
    int  n_long_rows;
    int  n_results;
    int  n_nonzero;
    int  widest;
    bit  idle_ok;
    bit  gap_mode;
    bit  stall_mode;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // before any line start the width is zero
        '{8'd255, 1'b0, 7'd64,  1'b1, 8'd0},
        '{8'd0,   1'b0, 7'd127, 1'b1, 8'd0},
        '{8'd170, 1'b0, 7'd85,  1'b1, 8'd0},
        // zero width row, bar width on a later item is ignored
        '{8'd255, 1'b1, 7'd0,   1'b1, 8'd0},
        '{8'd255, 1'b0, 7'd5,   1'b1, 8'd0},
        // width one: tap 0 passes the pixel at the row start
        '{8'd255, 1'b1, 7'd1,   1'b1, 8'd255},
        '{8'd0,   1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd255, 1'b0, 7'd0,   1'b0, 8'd0},
        // width above the maximum saturates, history flushed
        '{8'd200, 1'b1, 7'd127, 1'b1, 8'd0},
        '{8'd255, 1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd0,   1'b0, 7'd127, 1'b0, 8'd0},
        // bright bar of three in a width-three row
        '{8'd0,   1'b1, 7'd3,   1'b1, 8'd0},
        '{8'd0,   1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd255, 1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd255, 1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd255, 1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd0,   1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd0,   1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd0,   1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd0,   1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd255, 1'b1, 7'd2,   1'b1, 8'd0},
        '{8'd255, 1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd255, 1'b0, 7'd0,   1'b0, 8'd0},
        '{8'd85,  1'b1, 7'd64,  1'b1, 8'd0},
        '{8'd255, 1'b0, 7'd64,  1'b0, 8'd0}
    };

    lane_marking_bar_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .i_line_start (i_line_start),
        .i_bar_width  (i_bar_width),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered   (o_filtered)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("lane_marking_bar_filter test failed");
        $finish;
    end

    // center-surround response for one pixel, advances the row state
    function automatic logic [PIX_BITS-1:0] bar_response(logic [PIX_BITS-1:0] pix,
                                                          logic start,
                                                          logic [BAR_W_BITS-1:0] bw);
        int pos;
        int w;
        int lo;
        int acc;
        int p;
        int wt;
        if (start) begin
            row_w = (bw > MAX_BAR_WIDTH) ? MAX_BAR_WIDTH : int'(bw);
            pos   = 0;
        end else begin
            pos = line_pos;
        end
        w   = row_w;
        lo  = w / 2;
        acc = 0;
        for (int k = 0; k <= 2 * w; k++) begin
            if (w == 0)
                wt = 0;
            else if (k >= lo && k < lo + w)
                wt = 1;
            else if (k == 0 || k == 2 * w + 1)
                wt = 0;
            else
                wt = -1;
            if (k == 0)
                p = pix;
            else if (k <= pos)
                p = pix_hist[k-1];
            else
                p = 0;
            acc += wt * p;
        end
        if (acc < 0)
            acc = 0;
        if (acc > 255)
            acc = 255;
        for (int i = HIST_LEN - 1; i > 0; i--)
            pix_hist[i] = pix_hist[i-1];
        pix_hist[0] = pix;
        line_pos = (pos < 255) ? pos + 1 : 255;
        return acc[PIX_BITS-1:0];
    endfunction

    task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic start,
                              input logic [BAR_W_BITS-1:0] bw, input logic known,
                              input logic [PIX_BITS-1:0] filt);
        logic [PIX_BITS-1:0] predicted;
        if (idle_ok && gap_mode && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pixel      <= pix;
        i_line_start <= start;
        i_bar_width  <= bw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = bar_response(pix, start, bw);
        expected_filtered.push_back(known ? filt : predicted);
        n_items++;
        if (start)
            n_rows++;
        if (row_w > widest)
            widest = row_w;
    endtask

    // result side stalls in bursts
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_ok && stall_mode && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_filtered.size() == 0) begin
                $error("unexpected item on output, filtered %0d", o_filtered);
                n_errors++;
            end else begin
                if (o_filtered !== expected_filtered[0]) begin
                    $error("filtered mismatch: expected %0d, actual %0d",
                           expected_filtered[0], o_filtered);
                    n_errors++;
                end
                if (expected_filtered[0] != 0)
                    n_nonzero++;
                void'(expected_filtered.pop_front());
                n_results++;
            end
        end
    end

    initial begin
        int row_len;
        int bw_sel;
        int w;
        int style;
        int bg;
        int fg;
        int bar_len;
        int period;
        int phase;
        int drain;
        logic [BAR_W_BITS-1:0] bw;
        logic [PIX_BITS-1:0]   pix;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_pixel      <= '0;
        i_line_start <= 1'b0;
        i_bar_width  <= '0;
        n_errors     = 0;
        n_items      = 0;
        n_rows       = 0;
        n_long_rows  = 0;
        n_results    = 0;
        n_nonzero    = 0;
        widest       = 0;
        idle_ok      = 1'b1;
        gap_mode     = 1'b1;
        stall_mode   = 1'b1;
        line_pos     = 0;
        row_w        = 0;
        for (int i = 0; i < HIST_LEN; i++)
            pix_hist[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].pix, directed_rows[i].start, directed_rows[i].bw,
                       directed_rows[i].known, directed_rows[i].filt);

        while (n_items < N_ITEMS) begin
            bw_sel = $urandom_range(0, 9);
            case (bw_sel)
                0:       bw = BAR_W_BITS'($urandom_range(0, 1));
                7:       bw = BAR_W_BITS'($urandom_range(17, MAX_BAR_WIDTH));
                8:       bw = BAR_W_BITS'($urandom_range(MAX_BAR_WIDTH + 1, 127));
                9:       bw = BAR_W_BITS'($urandom_range(0, 127));
                default: bw = BAR_W_BITS'($urandom_range(1, 16));
            endcase
            w = (bw > MAX_BAR_WIDTH) ? MAX_BAR_WIDTH : int'(bw);
            // a few rows run past the saturation of the line position
            if (n_long_rows < 3 && $urandom_range(0, 11) == 0) begin
                row_len = $urandom_range(256, 300);
                n_long_rows++;
            end else begin
                row_len = $urandom_range(1, 2 * w + 24);
            end
            style   = $urandom_range(0, 5);
            bg      = $urandom_range(0, 90);
            fg      = $urandom_range(140, 255);
            bar_len = w + $urandom_range(0, 2) - 1;
            if (bar_len < 1)
                bar_len = 1;
            period  = bar_len + w + $urandom_range(2, 12);
            phase   = $urandom_range(0, period - 1);
            if (n_items > N_ITEMS - N_CALM)
                idle_ok = 1'b0;
            gap_mode   = $urandom_range(0, 2) != 0;
            stall_mode = $urandom_range(0, 2) != 0;
            for (int i = 0; i < row_len; i++) begin
                case (style)
                    0:       pix = PIX_BITS'($urandom_range(0, 255));
                    1:       pix = $urandom_range(0, 1) ? PIX_MAX : '0;
                    default: begin
                        // bright bars near the row width on a darker road
                        if ((i + phase) % period < bar_len)
                            pix = PIX_BITS'(fg - int'($urandom_range(0, 20)) < 0 ? 0 :
                                            fg - int'($urandom_range(0, 20)));
                        else
                            pix = PIX_BITS'(bg + $urandom_range(0, 25));
                    end
                endcase
                if (i == 0)
                    send_pixel(pix, 1'b1, bw, 1'b0, '0);
                else
                    send_pixel(pix, 1'b0, BAR_W_BITS'($urandom_range(0, 127)), 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        drain = 0;
        while (expected_filtered.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        if (expected_filtered.size() != 0) begin
            $error("%0d filtered results never arrived", expected_filtered.size());
            n_errors++;
        end
        repeat (10) @(posedge i_clk);

        $display("%0d pixels over %0d rows, widths up to %0d, %0d rows past position 255",
                 n_items, n_rows, widest, n_long_rows);
        $display("%0d results compared, %0d with a nonzero response", n_results, n_nonzero);
        if (n_errors == 0)
            $display("lane_marking_bar_filter test passed");
        else
            $display("lane_marking_bar_filter test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bmf_pkg.sv
sv/bmf_cell.sv
sv/bmf_line.sv
sv/lane_marking_bar_filter.sv
sv/bmf_checker.sv
dv/lane_marking_bar_filter_tb.sv
